@@ rtl/core/udec_pkg.sv @@
// ----------------------------------------------------------------------------
// udec_pkg
// shared constants and types for the 64-bit to decimal ascii streamer
// ----------------------------------------------------------------------------
package udec_pkg;

    localparam int VALUE_W       = 64;
    localparam int NUM_DIGITS    = 20;
    localparam int BITS_PER_STEP = 4;
    localparam int NUM_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(NUM_STEPS);
    localparam int IDX_W         = $clog2(NUM_DIGITS);
    localparam int CHAR_W        = 8;
    localparam int CNT_W         = 15;

    localparam int MAX_NUMBERS   = 1024;
    localparam int COUNT_LIMIT   = 32767;
    localparam int CHAR_CAP      = (MAX_NUMBERS * 20 > COUNT_LIMIT) ? COUNT_LIMIT
                                                                    : MAX_NUMBERS * 20;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NUL  = 8'h00;

    // converted number handed from the converter to the emitter
    typedef struct packed {
        logic [NUM_DIGITS-1:0][3:0] digits;
        logic [IDX_W-1:0]           top_idx;
        logic                       last;
    } udec_num_t;

endpackage

@@ rtl/core/udec_cell.sv @@
// ----------------------------------------------------------------------------
// udec_cell
// one bcd digit cell of the shift-and-add-3 chain, four bits per enabled cycle
// ----------------------------------------------------------------------------
module udec_cell (
    input  logic       aclk,
    input  logic       clear,
    input  logic       shift_en,
    input  logic [3:0] carry_in,
    output logic [3:0] carry_out,
    output logic [3:0] digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;

    // carry_in[k] enters at sub-step k, carry_out[k] leaves at sub-step k
    always_comb begin
        logic [3:0] d;
        logic [3:0] adj;
        d = digit_reg;
        adj = 4'd0;
        carry_out = 4'd0;
        for (int k = 0; k < udec_pkg::BITS_PER_STEP; k++) begin
            adj = (d >= 4'd5) ? d + 4'd3 : d;
            carry_out[k] = adj[3];
            d = {adj[2:0], carry_in[k]};
        end
        digit_next = d;
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            digit_reg <= 4'd0;
        end else if (shift_en) begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

@@ rtl/core/udec_conv.sv @@
// ----------------------------------------------------------------------------
// udec_conv
// binary to bcd converter: a row of digit cells fed four bits per cycle
// ----------------------------------------------------------------------------
module udec_conv (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [udec_pkg::VALUE_W-1:0]    s_value,
    input  logic                            s_batch_end,
    output logic                            res_valid,
    input  logic                            res_ready,
    output udec_pkg::udec_num_t             res
);

    typedef enum logic [1:0] {CV_IDLE, CV_RUN, CV_DONE} conv_state_t;

    conv_state_t                       state_reg;
    logic [udec_pkg::VALUE_W-1:0]      bin_reg;
    logic [udec_pkg::STEP_W-1:0]       step_reg;
    logic                              last_reg;

    logic                              accept;
    logic                              run;
    logic [3:0]                        carry [udec_pkg::NUM_DIGITS+1];
    logic [udec_pkg::NUM_DIGITS-1:0][3:0] digits;
    logic [udec_pkg::IDX_W-1:0]        top_idx;

    assign s_ready   = (state_reg == CV_IDLE) || ((state_reg == CV_DONE) && res_ready);
    assign accept    = s_valid && s_ready;
    assign run       = (state_reg == CV_RUN);
    assign res_valid = (state_reg == CV_DONE);

    // msb first into the least significant digit cell
    always_comb begin
        for (int k = 0; k < udec_pkg::BITS_PER_STEP; k++) begin
            carry[0][k] = bin_reg[udec_pkg::VALUE_W-1-k];
        end
    end

    for (genvar i = 0; i < udec_pkg::NUM_DIGITS; i++) begin : g_cell
        udec_cell u_cell (
            .aclk      (aclk),
            .clear     (accept),
            .shift_en  (run),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1]),
            .digit     (digits[i])
        );
    end

    // highest nonzero digit, zero for a value of zero
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < udec_pkg::NUM_DIGITS; i++) begin
            if (digits[i] != 4'd0) begin
                top_idx = udec_pkg::IDX_W'(i);
            end
        end
    end

    assign res.digits  = digits;
    assign res.top_idx = top_idx;
    assign res.last    = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
        end else begin
            unique case (state_reg)
                CV_IDLE: begin
                    if (accept) begin
                        state_reg <= CV_RUN;
                    end
                end
                CV_RUN: begin
                    bin_reg  <= bin_reg << udec_pkg::BITS_PER_STEP;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == udec_pkg::STEP_W'(udec_pkg::NUM_STEPS - 1)) begin
                        state_reg <= CV_DONE;
                    end
                end
                CV_DONE: begin
                    if (accept) begin
                        state_reg <= CV_RUN;
                    end else if (res_ready) begin
                        state_reg <= CV_IDLE;
                    end
                end
                default: begin
                    state_reg <= CV_IDLE;
                end
            endcase
            if (accept) begin
                bin_reg  <= s_value;
                last_reg <= s_batch_end;
                step_reg <= '0;
            end
        end
    end

endmodule

@@ rtl/core/udec_emit.sv @@
// ----------------------------------------------------------------------------
// udec_emit
// character emitter: walks the digits msd first, adds the terminator at a batch end,
// keeps the batch count and drives the registered output beat
// ----------------------------------------------------------------------------
module udec_emit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                res_valid,
    output logic                                res_ready,
    input  udec_pkg::udec_num_t                 res,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [udec_pkg::CHAR_W-1:0]         m_char_code,
    output logic                                m_number_done,
    output logic                                m_is_terminator,
    output logic [udec_pkg::CNT_W-1:0]          m_chars_so_far
);

    logic                                 active_reg;
    logic                                 term_phase_reg;
    logic                                 last_reg;
    logic [udec_pkg::IDX_W-1:0]           idx_reg;
    logic [udec_pkg::NUM_DIGITS-1:0][3:0] digits_reg;
    logic [udec_pkg::CNT_W-1:0]           count_reg;

    logic                                 m_valid_reg;
    logic [udec_pkg::CHAR_W-1:0]          char_reg;
    logic                                 done_reg;
    logic                                 term_reg;
    logic [udec_pkg::CNT_W-1:0]           chars_reg;

    logic                                 out_adv;
    logic                                 at_end;
    logic                                 load;
    logic [udec_pkg::CNT_W-1:0]           count_next;
    logic [3:0]                           cur_digit;

    assign out_adv   = active_reg && (!m_valid_reg || m_ready);
    assign at_end    = term_phase_reg || ((idx_reg == '0) && !last_reg);
    assign res_ready = !active_reg || (out_adv && at_end);
    assign load      = res_valid && res_ready;

    assign cur_digit  = digits_reg[idx_reg];
    assign count_next = (count_reg < udec_pkg::CNT_W'(udec_pkg::CHAR_CAP))
                      ? count_reg + 1'b1 : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            term_phase_reg <= 1'b0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (out_adv) begin
                m_valid_reg <= 1'b1;
                if (term_phase_reg) begin
                    char_reg       <= udec_pkg::ASCII_NUL;
                    done_reg       <= 1'b1;
                    term_reg       <= 1'b1;
                    chars_reg      <= count_reg;
                    count_reg      <= '0;
                    term_phase_reg <= 1'b0;
                end else begin
                    char_reg  <= udec_pkg::ASCII_ZERO + {4'd0, cur_digit};
                    done_reg  <= (idx_reg == '0) && !last_reg;
                    term_reg  <= 1'b0;
                    chars_reg <= count_next;
                    count_reg <= count_next;
                    if (idx_reg == '0) begin
                        if (last_reg) begin
                            term_phase_reg <= 1'b1;
                        end
                    end else begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // a new number takes over in the cycle the current one ends
            if (load) begin
                active_reg <= 1'b1;
            end else if (out_adv && at_end) begin
                active_reg <= 1'b0;
            end
            if (load) begin
                idx_reg        <= res.top_idx;
                digits_reg     <= res.digits;
                last_reg       <= res.last;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_char_code     = char_reg;
    assign m_number_done   = done_reg;
    assign m_is_terminator = term_reg;
    assign m_chars_so_far  = chars_reg;

endmodule

@@ rtl/core/u64_to_decimal_ascii_stream_top.sv @@
// ----------------------------------------------------------------------------
// u64_to_decimal_ascii_stream_top
// streams unsigned 64-bit numbers out as decimal ascii characters
// ----------------------------------------------------------------------------
// Each accepted number leaves as its decimal digits, most significant first,
// without leading zeros (zero gives a single '0'); a number flagged as the end
// of a batch is followed by a NUL beat. Every output beat carries the running
// character count of the batch (terminator excluded, saturating at 20480) and
// a flag on the last beat caused by the number. Conversion runs in a row of
// twenty bcd digit cells that take four bits of the number per cycle; the
// converted digits then move to the emitter, which sends one character per
// cycle unless m_ready stalls it. Conversion of the next number overlaps
// emission of the current one. The output beat sits in a register; while a
// beat waits on m_ready the emitter holds, but conversion can go on.
// ----------------------------------------------------------------------------
module u64_to_decimal_ascii_stream_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input beat: one number
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [udec_pkg::VALUE_W-1:0]        s_value,
    input  logic                                s_batch_end,
    // output beat: one character
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [udec_pkg::CHAR_W-1:0]         m_char_code,
    output logic                                m_number_done,
    output logic                                m_is_terminator,
    output logic [udec_pkg::CNT_W-1:0]          m_chars_so_far
);

    // converted number between the cell row and the emitter
    logic                res_valid;
    logic                res_ready;
    udec_pkg::udec_num_t res;

    // binary to bcd, one nibble per cycle through the cells while converting
    udec_conv u_conv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_batch_end (s_batch_end),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // one character per cycle into the output register unless m_ready stalls
    udec_emit u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_code     (m_char_code),
        .m_number_done   (m_number_done),
        .m_is_terminator (m_is_terminator),
        .m_chars_so_far  (m_chars_so_far)
    );

endmodule

@@ rtl/core/udec_checker.sv @@
// ----------------------------------------------------------------------------
// udec_checker
// port-level checks on the character stream
// ----------------------------------------------------------------------------
module udec_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [udec_pkg::CHAR_W-1:0]         m_char_code,
    input  logic                                m_number_done,
    input  logic                                m_is_terminator,
    input  logic [udec_pkg::CNT_W-1:0]          m_chars_so_far
);

    // the terminator is a nul and always closes the number
    a_term_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_terminator) |->
            (m_char_code == udec_pkg::ASCII_NUL) && m_number_done)
        else $error("terminator beat malformed");

    // every other beat is a decimal digit
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_terminator) |->
            (m_char_code >= udec_pkg::ASCII_ZERO) && (m_char_code <= 8'h39))
        else $error("non-digit character");

    // batch count never passes its cap
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_chars_so_far <= udec_pkg::CNT_W'(udec_pkg::CHAR_CAP)))
        else $error("character count above cap");

    // a stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            m_valid && $stable(m_char_code) && $stable(m_chars_so_far))
        else $error("output beat changed while stalled");

endmodule

bind u64_to_decimal_ascii_stream_top udec_checker u_udec_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_char_code     (m_char_code),
    .m_number_done   (m_number_done),
    .m_is_terminator (m_is_terminator),
    .m_chars_so_far  (m_chars_so_far)
);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 64-bit to decimal ascii streamer
// ----------------------------------------------------------------------------
// Numbers are queued up front and sent in bursts with random gaps. Every
// accepted number is converted here into the character beats it must cause,
// which wait in order until the output side accepts them. The output side
// stalls on a pattern that cycles through several modes. Stimulus covers the
// field extremes, zero, the digit-count boundaries, single-number batches,
// and one long batch of twenty-digit numbers.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // batch size limit of the block and the resulting character count cap
    localparam int MAX_NUMBERS = 1024;
    localparam int COUNT_CAP   = (MAX_NUMBERS * 20 > 32767) ? 32767 : MAX_NUMBERS * 20;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    localparam int RANDOM_NUMBERS = 290;
    localparam int LONG_NUMBERS   = 120;
    localparam int MAX_REPORTS    = 200;

    // one number waiting to be sent; hold makes the sender wait until every
    // expected character has come back before it offers this number
    typedef struct {
        logic [63:0] value;
        logic        batch_end;
        logic        hold;
    } number_item_t;

    // one expected character beat
    typedef struct {
        logic [7:0]  char_code;
        logic        number_done;
        logic        is_terminator;
        logic [14:0] chars_so_far;
    } char_beat_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                                s_valid     = 1'b0;
    logic                                s_ready;
    logic [udec_pkg::VALUE_W-1:0]        s_value     = '0;
    logic                                s_batch_end = 1'b0;

    logic                                m_valid;
    logic                                m_ready     = 1'b0;
    logic [udec_pkg::CHAR_W-1:0]         m_char_code;
    logic                                m_number_done;
    logic                                m_is_terminator;
    logic [udec_pkg::CNT_W-1:0]          m_chars_so_far;

    number_item_t pending_numbers[$];
    char_beat_t   expected_chars[$];

    // running character count of the current batch, as the block should hold it
    logic [14:0] batch_count = '0;

    // beats predicted (blocking, driver side) and beats received (nonblocking,
    // so the driver always sees the count from before the current edge)
    int chars_predicted = 0;
    int chars_received  = 0;
    int errors          = 0;

    // sender burst and gap state
    int burst_left = 0;
    int gap_left   = 0;

    // receiver stall pattern state
    logic [31:0] rx_cycle   = '0;
    int          stall_left = 0;

    u64_to_decimal_ascii_stream_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .s_batch_end     (s_batch_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_code     (m_char_code),
        .m_number_done   (m_number_done),
        .m_is_terminator (m_is_terminator),
        .m_chars_so_far  (m_chars_so_far)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [63:0] ten_pow(int k);
        logic [63:0] p;
        p = 64'd1;
        repeat (k) p = p * 64'd10;
        return p;
    endfunction

    // random number with a spread of digit counts and boundary values
    function automatic logic [63:0] rand_number();
        logic [63:0] lo;
        logic [63:0] span;
        logic [63:0] r;
        int          nd;
        int          pick;
        pick = $urandom_range(0, 9);
        r    = {$urandom, $urandom};
        if (pick < 4) begin
            // uniform within a chosen digit count
            nd   = $urandom_range(1, 20);
            lo   = ten_pow(nd - 1);
            span = (nd == 20) ? ~lo + 64'd1 : ten_pow(nd) - lo;
            return lo + r % span;
        end
        if (pick < 7)
            return r;
        if (pick == 7)
            return 64'($urandom_range(0, 99));
        if (pick == 8)
            // just below, at or just above a power of ten
            return ten_pow($urandom_range(1, 19)) + 64'($urandom_range(0, 2)) - 64'd1;
        return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
    endfunction

    task automatic queue_number(input logic [63:0] value, input logic batch_end,
                                input logic hold);
        number_item_t n;
        n.value     = value;
        n.batch_end = batch_end;
        n.hold      = hold;
        pending_numbers.push_back(n);
    endtask

    // expected beats for one accepted number: its digits, most significant
    // first, then a NUL beat when it closes the batch
    task automatic predict_chars(input logic [63:0] value, input logic batch_end);
        logic [3:0]  digs [20];
        logic [63:0] v;
        int          nd;
        char_beat_t  c;
        v  = value;
        nd = 0;
        do begin
            digs[nd] = 4'(v % 64'd10);
            v        = v / 64'd10;
            nd++;
        end while (v != 64'd0);
        for (int i = nd - 1; i >= 0; i--) begin
            if (batch_count < 15'(COUNT_CAP))
                batch_count++;
            c.char_code     = CHAR_ZERO + 8'(digs[i]);
            c.number_done   = (i == 0) && !batch_end;
            c.is_terminator = 1'b0;
            c.chars_so_far  = batch_count;
            expected_chars.push_back(c);
            chars_predicted++;
        end
        if (batch_end) begin
            c.char_code     = CHAR_NUL;
            c.number_done   = 1'b1;
            c.is_terminator = 1'b1;
            c.chars_so_far  = batch_count;
            expected_chars.push_back(c);
            chars_predicted++;
            batch_count = '0;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        // keep the log bounded when the block is badly broken
        if (errors < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        errors++;
    endtask

    // driver: offers numbers from the pending queue in bursts, predicts the
    // output of every number at the edge that accepts it
    always @(posedge aclk) begin : drive_numbers
        number_item_t nxt;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_value     <= '0;
            s_batch_end <= 1'b0;
            batch_count = '0;
        end else begin
            if (s_valid && s_ready)
                predict_chars(s_value, s_batch_end);
            // only touch the channel when no beat is left waiting
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_numbers.size() == 0 ||
                             (pending_numbers[0].hold && chars_predicted != chars_received)) begin
                    s_valid <= 1'b0;
                end else begin
                    nxt = pending_numbers.pop_front();
                    s_valid     <= 1'b1;
                    s_value     <= nxt.value;
                    s_batch_end <= nxt.batch_end;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // new burst: mostly short, now and then a long one
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                            8:          gap_left = $urandom_range(5, 20);
                            default:    gap_left = $urandom_range(21, 40);
                        endcase
                    end
                end
            end
        end
    end

    // monitor: checks each accepted character beat against the oldest
    // expectation and drives the stall pattern of the output side
    always @(posedge aclk) begin : watch_chars
        char_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                chars_received <= chars_received + 1;
                if (expected_chars.size() == 0) begin
                    flag_mismatch("unexpected beat, char_code", 64'hx, 64'(m_char_code));
                end else begin
                    want = expected_chars.pop_front();
                    if (m_char_code !== want.char_code)
                        flag_mismatch("char_code", 64'(want.char_code), 64'(m_char_code));
                    if (m_number_done !== want.number_done)
                        flag_mismatch("number_done", 64'(want.number_done),
                                      64'(m_number_done));
                    if (m_is_terminator !== want.is_terminator)
                        flag_mismatch("is_terminator", 64'(want.is_terminator),
                                      64'(m_is_terminator));
                    if (m_chars_so_far !== want.chars_so_far)
                        flag_mismatch("chars_so_far", 64'(want.chars_so_far),
                                      64'(m_chars_so_far));
                end
            end
            rx_cycle <= rx_cycle + 32'd1;
            // stall mode is picked by bits 10:9 of rx_cycle
            case (rx_cycle[10:9])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= ($urandom_range(0, 3) != 0);
                2'd2: m_ready <= (rx_cycle % 7) < 4;
                default: begin
                    // occasional long stalls
                    if (stall_left > 0) begin
                        stall_left--;
                        m_ready <= 1'b0;
                    end else if ($urandom_range(0, 4) == 0) begin
                        stall_left = $urandom_range(1, 12);
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // stimulus, reset and end of run
    initial begin : run_stimulus
        int n;
        int batch_len;
        logic hold;

        // directed numbers: zero, extremes, digit-count edges, short batches
        queue_number(64'd0, 1'b1, 1'b0);                      // batch of one zero
        queue_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        queue_number(64'd0, 1'b0, 1'b0);
        queue_number(64'd1, 1'b0, 1'b0);
        queue_number(64'd9, 1'b0, 1'b0);
        queue_number(64'd10, 1'b0, 1'b0);
        queue_number(64'd99, 1'b0, 1'b0);
        queue_number(64'd100, 1'b0, 1'b0);
        queue_number(ten_pow(19) - 64'd1, 1'b0, 1'b0);       // largest 19-digit number
        queue_number(ten_pow(19), 1'b0, 1'b0);               // smallest 20-digit number
        queue_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        queue_number(64'h8000_0000_0000_0000, 1'b1, 1'b0);
        queue_number(64'd5, 1'b1, 1'b0);                      // back-to-back batch ends
        queue_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
        queue_number(64'h5555_5555_5555_5555, 1'b1, 1'b0);
        queue_number(64'd42, 1'b1, 1'b0);

        // long batch of 20-digit numbers, each one emitting the most digits
        for (int i = 0; i < LONG_NUMBERS; i++)
            queue_number(ten_pow(19) + {$urandom, $urandom} % (~ten_pow(19) + 64'd1),
                         i == LONG_NUMBERS - 1, i == 0);

        // random batches, a few of them started only once the output is drained
        n = 0;
        while (n < RANDOM_NUMBERS) begin
            batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60)
                                                    : $urandom_range(1, 8);
            hold = (n == 0) || ($urandom_range(0, 29) == 0);
            for (int j = 0; j < batch_len; j++)
                queue_number(rand_number(), j == batch_len - 1, hold && j == 0);
            n += batch_len;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // all numbers accepted, then all characters back, then a quiet tail
        do @(negedge aclk); while (pending_numbers.size() != 0 || s_valid);
        do @(negedge aclk); while (expected_chars.size() != 0);
        repeat (60) @(negedge aclk);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
